// ===== src/incremental_world_state_hash_defines.svh =====
// Assertion macros for the incremental world state hash block
`ifndef INCREMENTAL_WORLD_STATE_HASH_DEFINES_SVH
`define INCREMENTAL_WORLD_STATE_HASH_DEFINES_SVH

// implication in the same cycle
`define IWSH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iwsh: same-cycle check failed");

// implication in the following cycle
`define IWSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iwsh: next-cycle check failed");

`endif

// ===== src/iwsh_pkg.sv =====
// Types and constants shared by the world state hash modules
`default_nettype none

package iwsh_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned PIN_W = 8;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LIM_W = 17;

  localparam logic [WORD_W-1:0] K_MSG = 64'h174b1ebe9d99d899;
  localparam logic [WORD_W-1:0] K_PROP = 64'hbef7d22dc910d44b;
  localparam logic [WORD_W-1:0] K_EXIT_FAIL = 64'h207bb7a8f6ceab58;
  localparam logic [WORD_W-1:0] K_EXIT_OK = 64'h5871d2579015cdc6;

  typedef enum logic [2:0] {
    OP_LOAD_DEV  = 3'd0,
    OP_LOAD_EDGE = 3'd1,
    OP_ADD_DEV   = 3'd2,
    OP_UPD_DEV   = 3'd3,
    OP_ADD_MSG   = 3'd4,
    OP_REM_MSG   = 3'd5,
    OP_EXIT      = 3'd6,
    OP_CLEAR     = 3'd7
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  index;
    logic [PIN_W-1:0]  pin;
    logic [WORD_W-1:0] value_a;
    logic [WORD_W-1:0] value_b;
    logic              exit_fail;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash_low;
    logic [WORD_W-1:0] hash_high;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [2*WORD_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== src/iwsh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none

module iwsh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/iwsh_mul.sv =====
// Shared 32x32 multiplier building a full 64x64 product one partial product at a time
`default_nettype none

module iwsh_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire iwsh_pkg::mul_req_t req_i,
  output iwsh_pkg::mul_rsp_t     rsp_o
);

  localparam int unsigned HalfW = iwsh_pkg::WORD_W / 2;
  localparam int unsigned ProdW = 2 * iwsh_pkg::WORD_W;
  localparam logic [2:0] LastStep = 3'd4;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [2:0]                    step_q, step_d;
  logic [iwsh_pkg::WORD_W-1:0]   x_q, y_q;
  logic [iwsh_pkg::WORD_W-1:0]   pp_q, pp_d;
  logic [1:0]                    sh_q, sh_d;
  logic [ProdW-1:0]              prod_q;
  logic [HalfW-1:0]              xi, yj;
  logic [ProdW-1:0]              pp_wide;

  always_comb begin
    xi = step_q[1] ? x_q[iwsh_pkg::WORD_W-1:HalfW] : x_q[HalfW-1:0];
    yj = step_q[0] ? y_q[iwsh_pkg::WORD_W-1:HalfW] : y_q[HalfW-1:0];
    pp_d = iwsh_pkg::WORD_W'(xi) * iwsh_pkg::WORD_W'(yj);
    sh_d = {1'b0, step_q[1]} + {1'b0, step_q[0]};
    case (sh_q)
      2'd0:    pp_wide = {{iwsh_pkg::WORD_W{1'b0}}, pp_q};
      2'd1:    pp_wide = {{HalfW{1'b0}}, pp_q, {HalfW{1'b0}}};
      default: pp_wide = {pp_q, {iwsh_pkg::WORD_W{1'b0}}};
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.x;
      y_q    <= req_i.y;
      prod_q <= '0;
    end else if (busy_q) begin
      if (step_q != LastStep) begin
        pp_q <= pp_d;
        sh_q <= sh_d;
      end
      if (step_q != 3'd0) begin
        prod_q <= prod_q + pp_wide;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

`default_nettype wire

// ===== src/incremental_world_state_hash.sv =====
// Top level of the incremental world state hash: salt tables, sequencer, accumulator
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+------------------------
//   in      | to block  | in_item_t   | in_valid_i / in_stall_o
//   out     | from block| out_item_t  | out_valid_o / out_stall_i
//
// Salt loads, exit and clear use no product; add device uses one, update device
// two, add or remove message four. Each 64x64 product runs on the single shared
// 32x32 multiplier (four partial products, one drain, handoff).
// One item at a time; in_stall_o is high from accept until the result is registered.
// A stalled result waits in the output register while the next item is taken.
// Reset clears the accumulator and control; salt tables hold no reset value.
`default_nettype none

`include "incremental_world_state_hash_defines.svh"

module incremental_world_state_hash #(
  parameter int unsigned DEVICES = 1024,
  parameter int unsigned EDGES = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire iwsh_pkg::in_item_t   in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output iwsh_pkg::out_item_t       out_o
);

  localparam int unsigned DevAw = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int unsigned EdgeAw = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int unsigned WordW = iwsh_pkg::WORD_W;
  localparam int unsigned AccW = 2 * WordW;

  typedef logic [iwsh_pkg::LIM_W-1:0] lim_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [1:0]             phase_q, phase_d;
  logic                   out_valid_q, out_valid_d;
  iwsh_pkg::out_item_t    out_q, out_d;
  logic [AccW-1:0]        acc_q, acc_d;

  iwsh_pkg::op_e          op_q;
  logic [iwsh_pkg::PIN_W-1:0] pin_q;
  logic [WordW-1:0]       va_q, vb_q, salt_q, a_q, b_q;
  logic                   rng_q;

  logic                   in_acc;
  logic                   dev_rng, edge_rng, is_msg_in;
  logic                   acc_en, acc_sub, acc_clr;
  logic [AccW-1:0]        addend;
  logic [AccW-1:0]        addend_x;

  logic                   dev_we, edge_we;
  logic [DevAw-1:0]       dev_addr;
  logic [EdgeAw-1:0]      edge_addr;
  logic [WordW-1:0]       dev_rdata, edge_rdata, salt_wdata;

  iwsh_pkg::mul_req_t     mul_req;
  iwsh_pkg::mul_rsp_t     mul_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && (state_q == S_IDLE);

  assign dev_rng = lim_t'(in_i.index) < lim_t'(DEVICES);
  assign edge_rng = lim_t'(in_i.index) < lim_t'(EDGES);
  assign is_msg_in = (in_i.op == iwsh_pkg::OP_ADD_MSG) || (in_i.op == iwsh_pkg::OP_REM_MSG);

  assign dev_addr = DevAw'(in_i.index);
  assign edge_addr = EdgeAw'(in_i.index);
  assign salt_wdata = in_i.value_a | {{(WordW-1){1'b0}}, 1'b1};
  assign dev_we = in_acc && (in_i.op == iwsh_pkg::OP_LOAD_DEV) && dev_rng;
  assign edge_we = in_acc && (in_i.op == iwsh_pkg::OP_LOAD_EDGE) && edge_rng;

  iwsh_ram #(
    .WIDTH(WordW),
    .DEPTH(DEVICES)
  ) u_dev_salt (
    .clk_i  (clk_i),
    .we_i   (dev_we),
    .waddr_i(dev_addr),
    .wdata_i(salt_wdata),
    .raddr_i(dev_addr),
    .rdata_o(dev_rdata)
  );

  iwsh_ram #(
    .WIDTH(WordW),
    .DEPTH(EDGES)
  ) u_edge_salt (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_addr),
    .wdata_i(salt_wdata),
    .raddr_i(edge_addr),
    .rdata_o(edge_rdata)
  );

  iwsh_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_req.start = (state_q == S_MUL_GO);
    mul_req.x = salt_q;
    mul_req.y = va_q;
    case (op_q) inside
      iwsh_pkg::OP_UPD_DEV: begin
        mul_req.y = (phase_q == 2'd0) ? va_q : vb_q;
      end
      iwsh_pkg::OP_ADD_MSG, iwsh_pkg::OP_REM_MSG: begin
        case (phase_q)
          2'd0: begin
            mul_req.x = salt_q;
            mul_req.y = {{(WordW-iwsh_pkg::PIN_W-1){1'b0}}, pin_q, 1'b1};
          end
          2'd1: begin
            mul_req.x = va_q;
            mul_req.y = iwsh_pkg::K_MSG;
          end
          2'd2: begin
            mul_req.x = vb_q;
            mul_req.y = iwsh_pkg::K_PROP;
          end
          default: begin
            mul_req.x = a_q;
            mul_req.y = b_q;
          end
        endcase
      end
      default: begin
        mul_req.y = va_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    acc_en = 1'b0;
    acc_sub = 1'b0;
    acc_clr = 1'b0;
    addend = mul_rsp.prod;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_i.op) inside
            iwsh_pkg::OP_LOAD_DEV, iwsh_pkg::OP_LOAD_EDGE: begin
              state_d = S_DONE;
            end
            iwsh_pkg::OP_EXIT: begin
              acc_en = 1'b1;
              addend = {{WordW{1'b0}},
                        in_i.exit_fail ? iwsh_pkg::K_EXIT_FAIL : iwsh_pkg::K_EXIT_OK};
              state_d = S_DONE;
            end
            iwsh_pkg::OP_CLEAR: begin
              acc_clr = 1'b1;
              state_d = S_DONE;
            end
            default: begin
              phase_d = 2'd0;
              state_d = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_MUL_GO;
      end
      S_MUL_GO: begin
        state_d = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_rsp.done) begin
          case (op_q) inside
            iwsh_pkg::OP_ADD_DEV: begin
              acc_en = 1'b1;
              state_d = S_DONE;
            end
            iwsh_pkg::OP_UPD_DEV: begin
              acc_en = 1'b1;
              if (phase_q == 2'd0) begin
                acc_sub = 1'b1;
                phase_d = 2'd1;
                state_d = S_MUL_GO;
              end else begin
                state_d = S_DONE;
              end
            end
            iwsh_pkg::OP_ADD_MSG, iwsh_pkg::OP_REM_MSG: begin
              if (phase_q == 2'd3) begin
                acc_en = 1'b1;
                acc_sub = (op_q == iwsh_pkg::OP_REM_MSG);
                state_d = S_DONE;
              end else begin
                phase_d = phase_q + 2'd1;
                state_d = S_MUL_GO;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.hash_low = acc_q[WordW-1:0];
          out_d.hash_high = acc_q[AccW-1:WordW];
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign addend_x = acc_sub ? ~addend : addend;

  always_comb begin
    if (acc_clr) begin
      acc_d = '0;
    end else if (acc_en) begin
      acc_d = acc_q + addend_x + {{(AccW-1){1'b0}}, acc_sub};
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      acc_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      out_valid_q <= out_valid_d;
      out_q <= out_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_i.op;
      pin_q <= in_i.pin;
      va_q <= in_i.value_a;
      vb_q <= in_i.value_b;
      rng_q <= is_msg_in ? edge_rng : dev_rng;
    end
    if (state_q == S_READ) begin
      if (!rng_q) begin
        salt_q <= '0;
      end else if ((op_q == iwsh_pkg::OP_ADD_MSG) || (op_q == iwsh_pkg::OP_REM_MSG)) begin
        salt_q <= edge_rdata;
      end else begin
        salt_q <= dev_rdata;
      end
    end
    if ((state_q == S_MUL_WAIT) && mul_rsp.done) begin
      case (phase_q)
        2'd0: a_q <= mul_rsp.prod[WordW-1:0];
        2'd1: b_q <= mul_rsp.prod[WordW-1:0];
        2'd2: b_q <= b_q + mul_rsp.prod[WordW-1:0];
        default: b_q <= b_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

  `IWSH_ASSERT_SAME(a_done_in_wait, mul_rsp.done, state_q == S_MUL_WAIT)
  `IWSH_ASSERT_SAME(a_start_when_free, mul_req.start, !mul_rsp.busy)
  `IWSH_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE)
  `IWSH_ASSERT_NEXT(a_clear_zeroes, in_acc && (in_i.op == iwsh_pkg::OP_CLEAR), acc_q == '0)

endmodule

`default_nettype wire
